[sv/bps_pkg.sv]
// Shared types and constants for the beep pattern sequencer.
// No dependencies; every other file refers to this package by scoped names.
package bps_pkg;

    localparam int ACTION_W    = 3;
    localparam int FIELD_TIME_W = 32;
    localparam int FIELD_LEN_W  = 16;
    localparam int FIELD_CNT_W  = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BEEP   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MUTE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNMUTE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE = 3'd4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPACING   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLIP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROLLOVER  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ON_LEVEL  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFF_LEVEL = 3'd4;

    // Register reset values
    localparam logic [FIELD_LEN_W-1:0]  SPACING_RESET  = 16'd100;
    localparam logic [FIELD_LEN_W-1:0]  BLIP_RESET     = 16'd50;
    localparam logic [CFG_DATA_W-1:0]   ROLLOVER_RESET = 32'd50000;
    localparam logic                    ON_RESET       = 1'b1;
    localparam logic                    OFF_RESET      = 1'b0;

    // Blip counts for mute and unmute
    localparam logic [FIELD_CNT_W-1:0] MUTE_BLIPS   = 16'd2;
    localparam logic [FIELD_CNT_W-1:0] UNMUTE_BLIPS = 16'd3;

    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [FIELD_TIME_W-1:0] now_ms;
        logic [FIELD_LEN_W-1:0]  duration_ms;
        logic [FIELD_CNT_W-1:0]  beep_count;
    } item_t;

    typedef struct packed {
        logic [FIELD_LEN_W-1:0] spacing_ms;
        logic [FIELD_LEN_W-1:0] blip_ms;
        logic [CFG_DATA_W-1:0]  rollover_threshold;
        logic                   on_level;
        logic                   off_level;
    } cfg_t;

    typedef struct packed {
        logic pin_write;
        logic pin_level;
        logic muted;
    } result_t;

endpackage

[sv/bps_cfg_regs.sv]
// Configuration register bank of the beep pattern sequencer.
// Depends on bps_pkg for the register indexes, reset values and cfg_t.
module bps_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bps_pkg::cfg_t                  cfg
);

    bps_pkg::cfg_t cfg_reg;
    bps_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bps_pkg::CFG_SPACING:
                    cfg_next.spacing_ms = cfg_data[bps_pkg::FIELD_LEN_W-1:0];
                bps_pkg::CFG_BLIP:
                    cfg_next.blip_ms = cfg_data[bps_pkg::FIELD_LEN_W-1:0];
                bps_pkg::CFG_ROLLOVER:
                    cfg_next.rollover_threshold = cfg_data;
                bps_pkg::CFG_ON_LEVEL:
                    cfg_next.on_level = cfg_data[0];
                bps_pkg::CFG_OFF_LEVEL:
                    cfg_next.off_level = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spacing_ms         <= bps_pkg::SPACING_RESET;
            cfg_reg.blip_ms            <= bps_pkg::BLIP_RESET;
            cfg_reg.rollover_threshold <= bps_pkg::ROLLOVER_RESET;
            cfg_reg.on_level           <= bps_pkg::ON_RESET;
            cfg_reg.off_level          <= bps_pkg::OFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/bps_in_stage.sv]
// Input register of the beep pattern sequencer: holds one accepted beat.
// Depends on bps_pkg for item_t.
module bps_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bps_pkg::item_t in_item,
    input  logic           advance,
    output logic           held_valid,
    output bps_pkg::item_t held_item
);

    logic           valid_reg;
    logic           valid_next;
    bps_pkg::item_t item_reg;
    logic           take;

    // Free when empty or when the held beat moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

[sv/bps_engine.sv]
// Sequencer state and next-state logic of the beep pattern sequencer.
// Depends on bps_pkg for item_t, cfg_t, result_t and the action codes.
module bps_engine
#(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  bps_pkg::item_t   item,
    input  bps_pkg::cfg_t    cfg,
    output bps_pkg::result_t result
);

    localparam int CMP_W = (TIME_WIDTH > bps_pkg::CFG_DATA_W) ? TIME_WIDTH
                                                              : bps_pkg::CFG_DATA_W;

    logic                           mute_mode_reg,   mute_mode_next;
    logic [COUNT_WIDTH-1:0]         beeps_left_reg,  beeps_left_next;
    logic [bps_pkg::FIELD_LEN_W-1:0] beep_length_reg, beep_length_next;
    logic                           in_gap_reg,      in_gap_next;
    logic [TIME_WIDTH-1:0]          target_time_reg, target_time_next;
    logic                           driven_level_reg, driven_level_next;
    logic                           wrote;

    logic [TIME_WIDTH-1:0]           now;
    logic [COUNT_WIDTH-1:0]          req_cnt;
    logic [TIME_WIDTH-1:0]           ahead;
    logic                            reached;
    logic                            run_req;
    logic                            run_block;
    logic [bps_pkg::FIELD_LEN_W-1:0] run_len;
    logic [COUNT_WIDTH-1:0]          run_cnt;
    logic                            do_tick;

    assign now     = TIME_WIDTH'(item.now_ms);
    assign req_cnt = COUNT_WIDTH'(item.beep_count);
    assign ahead   = target_time_reg - now;
    assign reached = (now >= target_time_reg)
                  || (CMP_W'(ahead) > CMP_W'(cfg.rollover_threshold));

    // Decode the action into a run request and the mute update
    always_comb
    begin
        run_req        = 1'b0;
        run_block      = mute_mode_reg;
        run_len        = item.duration_ms;
        run_cnt        = req_cnt;
        mute_mode_next = mute_mode_reg;
        do_tick        = 1'b0;
        case (item.action)
            bps_pkg::ACT_TICK:
            begin
                do_tick = 1'b1;
            end
            bps_pkg::ACT_BEEP:
            begin
                run_req = 1'b1;
            end
            bps_pkg::ACT_MUTE:
            begin
                run_req        = 1'b1;
                run_len        = cfg.blip_ms;
                run_cnt        = COUNT_WIDTH'(bps_pkg::MUTE_BLIPS);
                mute_mode_next = 1'b1;
            end
            bps_pkg::ACT_UNMUTE:
            begin
                run_req        = 1'b1;
                run_block      = 1'b0;
                run_len        = cfg.blip_ms;
                run_cnt        = COUNT_WIDTH'(bps_pkg::UNMUTE_BLIPS);
                mute_mode_next = 1'b0;
            end
            bps_pkg::ACT_TOGGLE:
            begin
                run_req        = 1'b1;
                run_block      = 1'b0;
                run_len        = cfg.blip_ms;
                mute_mode_next = !mute_mode_reg;
                if (mute_mode_reg)
                begin
                    run_cnt = COUNT_WIDTH'(bps_pkg::UNMUTE_BLIPS);
                end
                else
                begin
                    run_cnt = COUNT_WIDTH'(bps_pkg::MUTE_BLIPS);
                end
            end
            default:
            begin
                run_req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        beeps_left_next   = beeps_left_reg;
        beep_length_next  = beep_length_reg;
        in_gap_next       = in_gap_reg;
        target_time_next  = target_time_reg;
        driven_level_next = driven_level_reg;
        wrote             = 1'b0;
        if (run_req && (run_cnt != '0) && !run_block)
        begin
            wrote             = 1'b1;
            driven_level_next = cfg.on_level;
            beep_length_next  = run_len;
            beeps_left_next   = run_cnt - COUNT_WIDTH'(1);
            in_gap_next       = 1'b0;
            target_time_next  = now + TIME_WIDTH'(run_len);
        end
        else if (do_tick && reached)
        begin
            wrote = 1'b1;
            if (beeps_left_reg == '0)
            begin
                driven_level_next = cfg.off_level;
            end
            else if (!in_gap_reg)
            begin
                driven_level_next = cfg.off_level;
                in_gap_next       = 1'b1;
                target_time_next  = target_time_reg + TIME_WIDTH'(cfg.spacing_ms);
            end
            else
            begin
                driven_level_next = cfg.on_level;
                in_gap_next       = 1'b0;
                target_time_next  = target_time_reg + TIME_WIDTH'(beep_length_reg);
                beeps_left_next   = beeps_left_reg - COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_mode_reg    <= 1'b0;
            beeps_left_reg   <= '0;
            beep_length_reg  <= '0;
            in_gap_reg       <= 1'b0;
            target_time_reg  <= '0;
            driven_level_reg <= 1'b0;
        end
        else if (fire)
        begin
            mute_mode_reg    <= mute_mode_next;
            beeps_left_reg   <= beeps_left_next;
            beep_length_reg  <= beep_length_next;
            in_gap_reg       <= in_gap_next;
            target_time_reg  <= target_time_next;
            driven_level_reg <= driven_level_next;
        end
    end

    assign result.pin_write = wrote;
    assign result.pin_level = driven_level_next;
    assign result.muted     = mute_mode_next;

`ifndef NO_ASSERTIONS
    // A gap always has a beep still to come after it
    a_gap_has_beeps: assert property (@(posedge clk) disable iff (!rst_n)
        in_gap_reg |-> (beeps_left_reg != '0))
        else $error("in gap with no beeps left");

    // The pin level only moves on a beat that writes the pin
    a_level_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !wrote) |=> (driven_level_reg == $past(driven_level_reg)))
        else $error("pin level changed without a write");

    // Mute always ends muted
    a_mute_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.action == bps_pkg::ACT_MUTE)) |=> mute_mode_reg)
        else $error("mute did not set mute mode");

    // Unmute always clears mute and starts the blips at the on level
    a_unmute_blips: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (item.action == bps_pkg::ACT_UNMUTE))
        |=> (!mute_mode_reg && (driven_level_reg == $past(cfg.on_level))))
        else $error("unmute did not start blips");

    // Run state holds between beats
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(target_time_reg) && $stable(beeps_left_reg)))
        else $error("run state moved without a beat");
`endif

endmodule

[sv/bps_out_stage.sv]
// Result register of the beep pattern sequencer.
// Depends on bps_pkg for result_t.
module bps_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  bps_pkg::result_t result,
    output logic             free,
    output logic             out_valid,
    input  logic             out_ready,
    output bps_pkg::result_t out_result
);

    logic             valid_reg;
    logic             valid_next;
    bps_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

[sv/beep_pattern_sequencer_core.sv]
// Top level of the beep pattern sequencer.
// Depends on bps_pkg, bps_cfg_regs, bps_in_stage, bps_engine and bps_out_stage.
//
// Drives one buzzer pin through runs of beeps. Each input beat carries the
// millisecond time and an action (tick, beep request, mute, unmute, toggle
// mute); every beat returns exactly one result beat with pin_write, the
// level now on the pin and the mute mode. The block takes one beat per
// clock while out_ready keeps up: a beat waits in the input register until
// a single compare-and-add pass updates the sequencer state and loads the
// result register, so a result is offered once its beat has passed through
// both the input register and the result register, and the next beat may
// enter in the same cycle the previous one is processed.
// Throughput is set only by out_ready; while a result waits, the input
// register still holds one more beat. Configuration writes through
// cfg_write/cfg_index/cfg_data take effect on the next clock and should be
// issued only while no beat is in flight.
module beep_pattern_sequencer_core
#(
    parameter int TIME_WIDTH  = 32,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bps_pkg::ACTION_W-1:0]    action,
    input  logic [bps_pkg::FIELD_TIME_W-1:0] now_ms,
    input  logic [bps_pkg::FIELD_LEN_W-1:0] duration_ms,
    input  logic [bps_pkg::FIELD_CNT_W-1:0] beep_count,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            pin_write,
    output logic                            pin_level,
    output logic                            muted,

    input  logic                            cfg_write,
    input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bps_pkg::cfg_t    cfg;
    bps_pkg::item_t   in_item;
    bps_pkg::item_t   held_item;
    bps_pkg::result_t result;
    bps_pkg::result_t out_result;
    logic             held_valid;
    logic             out_free;
    logic             fire;

    // Pack the input ports into one beat
    assign in_item.action      = action;
    assign in_item.now_ms      = now_ms;
    assign in_item.duration_ms = duration_ms;
    assign in_item.beep_count  = beep_count;

    // Process the held beat whenever the result register can take its result
    assign fire = held_valid && out_free;

    bps_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (out_free),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    bps_engine
    #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (held_item),
        .cfg    (cfg),
        .result (result)
    );

    bps_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .free       (out_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_result (out_result)
    );

    // Unpack the result beat onto the output ports
    assign pin_write = out_result.pin_write;
    assign pin_level = out_result.pin_level;
    assign muted     = out_result.muted;

endmodule

[test/tb.sv]
// Self-checking testbench for beep_pattern_sequencer_core.
// Depends on bps_pkg and the RTL of the block. A predictor inside the bench tracks
// the sequencer state, and every result beat is checked against it.
module tb;

    localparam int PERIOD_HALF = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 110;
    // first action code the block does not define
    localparam logic [bps_pkg::ACTION_W-1:0] ACT_SPARE = bps_pkg::ACT_TOGGLE + 1'b1;
    // highest action code, also undefined
    localparam logic [bps_pkg::ACTION_W-1:0] ACT_SPARE_TOP = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [bps_pkg::ACTION_W-1:0]     action = '0;
    logic [bps_pkg::FIELD_TIME_W-1:0] now_ms = '0;
    logic [bps_pkg::FIELD_LEN_W-1:0]  duration_ms = '0;
    logic [bps_pkg::FIELD_CNT_W-1:0]  beep_count = '0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic pin_write;
    logic pin_level;
    logic muted;

    logic                            cfg_write = 1'b0;
    logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    beep_pattern_sequencer_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .now_ms      (now_ms),
        .duration_ms (duration_ms),
        .beep_count  (beep_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pin_write   (pin_write),
        .pin_level   (pin_level),
        .muted       (muted),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Free-running clock.
    always #PERIOD_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: shadow copy of the register file and sequencer state.
    // ------------------------------------------------------------------
    logic [bps_pkg::FIELD_LEN_W-1:0]  spacing_r  = bps_pkg::SPACING_RESET;
    logic [bps_pkg::FIELD_LEN_W-1:0]  blip_r     = bps_pkg::BLIP_RESET;
    logic [bps_pkg::CFG_DATA_W-1:0]   rollover_r = bps_pkg::ROLLOVER_RESET;
    logic                             on_r       = bps_pkg::ON_RESET;
    logic                             off_r      = bps_pkg::OFF_RESET;

    logic                             seq_muted  = 1'b0;
    logic [bps_pkg::FIELD_CNT_W-1:0]  seq_left   = '0;   // beeps still to start after this one
    logic [bps_pkg::FIELD_LEN_W-1:0]  seq_len    = '0;
    logic                             seq_gap    = 1'b0;
    logic [bps_pkg::FIELD_TIME_W-1:0] seq_target = '0;
    logic                             seq_level  = 1'b0;
    logic                             seq_touched;

    function automatic void drive_pin(logic lvl);
        seq_level   = lvl;
        seq_touched = 1'b1;
    endfunction

    // Start a run; a zero count or mute mode drops the request.
    function automatic void launch_run(logic [bps_pkg::FIELD_TIME_W-1:0] t,
                                       logic [bps_pkg::FIELD_LEN_W-1:0] len,
                                       logic [bps_pkg::FIELD_CNT_W-1:0] cnt);
        if (cnt != '0 && !seq_muted)
        begin
            drive_pin(on_r);
            seq_len    = len;
            seq_left   = cnt - 1'b1;
            seq_gap    = 1'b0;
            seq_target = t + len;
        end
    endfunction

    function automatic void enter_mute(logic [bps_pkg::FIELD_TIME_W-1:0] t);
        launch_run(t, blip_r, bps_pkg::MUTE_BLIPS);
        seq_muted = 1'b1;
    endfunction

    function automatic void leave_mute(logic [bps_pkg::FIELD_TIME_W-1:0] t);
        seq_muted = 1'b0;
        launch_run(t, blip_r, bps_pkg::UNMUTE_BLIPS);
    endfunction

    // Advance the run once the target time is reached or has wrapped.
    function automatic void on_tick(logic [bps_pkg::FIELD_TIME_W-1:0] t);
        logic [bps_pkg::FIELD_TIME_W-1:0] ahead;
        ahead = seq_target - t;
        if (t >= seq_target || ahead > rollover_r)
        begin
            if (seq_left == '0)
                drive_pin(off_r);
            else if (!seq_gap)
            begin
                drive_pin(off_r);
                seq_gap    = 1'b1;
                seq_target = seq_target + spacing_r;
            end
            else
            begin
                drive_pin(on_r);
                seq_gap    = 1'b0;
                seq_target = seq_target + seq_len;
                seq_left   = seq_left - 1'b1;
            end
        end
    endfunction

    function automatic bps_pkg::result_t buzzer_predict(bps_pkg::item_t it);
        bps_pkg::result_t r;
        seq_touched = 1'b0;
        case (it.action)
            bps_pkg::ACT_TICK:   on_tick(it.now_ms);
            bps_pkg::ACT_BEEP:   launch_run(it.now_ms, it.duration_ms, it.beep_count);
            bps_pkg::ACT_MUTE:   enter_mute(it.now_ms);
            bps_pkg::ACT_UNMUTE: leave_mute(it.now_ms);
            bps_pkg::ACT_TOGGLE:
            begin
                if (seq_muted)
                    leave_mute(it.now_ms);
                else
                    enter_mute(it.now_ms);
            end
            default: ;
        endcase
        r.pin_write = seq_touched;
        r.pin_level = seq_level;
        r.muted     = seq_muted;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    bps_pkg::item_t   beat_q[$];        // beats waiting to be offered
    bps_pkg::result_t pin_expect_q[$];  // predicted results, oldest first
    int      fail_cnt    = 0;
    int      checked_cnt = 0;
    int      sent_cnt    = 0;
    int      cycle_cnt   = 0;
    bit      send_idle   = 1'b1;
    bit      recv_idle   = 1'b1;
    int      hold_req    = 0;
    int      hold_served = 0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_pause(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer beats from beat_q, predict each one as it is accepted.
    // ------------------------------------------------------------------
    bps_pkg::item_t beat_cur;
    int    gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pin_expect_q.push_back(buzzer_predict(beat_cur));
                sent_cnt++;
            end
            // Hold the beat until it is taken; otherwise idle or load the next one.
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (beat_q.size() != 0)
                begin
                    beat_cur = beat_q.pop_front();
                    action      <= beat_cur.action;
                    now_ms      <= beat_cur.now_ms;
                    duration_ms <= beat_cur.duration_ms;
                    beep_count  <= beat_cur.beep_count;
                    in_valid    <= 1'b1;
                    gap_left = pick_pause(send_idle);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall the output at random, check each result beat.
    // ------------------------------------------------------------------
    int               stall_left = 0;
    bps_pkg::result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pin_expect_q.size() == 0)
                begin
                    $error("result beat arrived with nothing expected");
                    fail_cnt++;
                end
                else
                begin
                    want = pin_expect_q.pop_front();
                    checked_cnt++;
                    if (pin_write !== want.pin_write)
                    begin
                        $error("pin_write: expected %0b, got %0b", want.pin_write, pin_write);
                        fail_cnt++;
                    end
                    if (pin_level !== want.pin_level)
                    begin
                        $error("pin_level: expected %0b, got %0b", want.pin_level, pin_level);
                        fail_cnt++;
                    end
                    if (muted !== want.muted)
                    begin
                        $error("muted: expected %0b, got %0b", want.muted, muted);
                        fail_cnt++;
                    end
                end
            end
            // A long hold-off lets the block fill up and back-pressure its input.
            if (hold_served != hold_req)
            begin
                hold_served = hold_req;
                stall_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_pause(recv_idle);
                out_ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results pending",
                     cycle_cnt, pin_expect_q.size());
            $display("beep_pattern_sequencer_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [bps_pkg::FIELD_TIME_W-1:0] cur_ms = '0;
    int step_max = 60;
    int dur_max  = 60;
    int phase_items = 0;
    int setting_cnt = 1;

    task automatic push_beat(logic [bps_pkg::ACTION_W-1:0] act,
                             logic [bps_pkg::FIELD_TIME_W-1:0] t,
                             logic [bps_pkg::FIELD_LEN_W-1:0] dur,
                             logic [bps_pkg::FIELD_CNT_W-1:0] cnt);
        bps_pkg::item_t it;
        it.action      = act;
        it.now_ms      = t;
        it.duration_ms = dur;
        it.beep_count  = cnt;
        beat_q.push_back(it);
        phase_items++;
    endtask

    // Register writes; the shadow copy follows at once since the block is idle.
    task automatic write_reg(logic [bps_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bps_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            bps_pkg::CFG_SPACING:   spacing_r  = val[bps_pkg::FIELD_LEN_W-1:0];
            bps_pkg::CFG_BLIP:      blip_r     = val[bps_pkg::FIELD_LEN_W-1:0];
            bps_pkg::CFG_ROLLOVER:  rollover_r = val;
            bps_pkg::CFG_ON_LEVEL:  on_r       = val[0];
            bps_pkg::CFG_OFF_LEVEL: off_r      = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_regs(logic [15:0] spc, logic [15:0] blp, logic [31:0] roll,
                            logic lvl_on, logic lvl_off);
        write_reg(bps_pkg::CFG_SPACING, {16'd0, spc});
        write_reg(bps_pkg::CFG_BLIP, {16'd0, blp});
        write_reg(bps_pkg::CFG_ROLLOVER, roll);
        write_reg(bps_pkg::CFG_ON_LEVEL, {31'd0, lvl_on});
        write_reg(bps_pkg::CFG_OFF_LEVEL, {31'd0, lvl_off});
        setting_cnt++;
    endtask

    // Drain everything in flight, then let the pipeline settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (beat_q.size() != 0 || in_valid || pin_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [bps_pkg::FIELD_CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 85)
            return bps_pkg::FIELD_CNT_W'($urandom_range(1, 4));
        return bps_pkg::FIELD_CNT_W'($urandom());
    endfunction

    // One well-formed sequence: a start (beep, mute, unmute or toggle) and a run
    // of ticks (now and then a toggle) with rising time, sometimes next to the 32-bit wrap.
    task automatic gen_run();
        int r;
        int n_ticks;
        r = $urandom_range(0, 99);
        if (r < 15)
            cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * step_max);
        else if (r < 25)
            cur_ms = $urandom();
        else
            cur_ms = cur_ms + $urandom_range(0, step_max);
        r = $urandom_range(0, 99);
        if (r < 60)
            push_beat(bps_pkg::ACT_BEEP, cur_ms,
                      bps_pkg::FIELD_LEN_W'($urandom_range(0, dur_max)), pick_count());
        else if (r < 75)
            push_beat(bps_pkg::ACT_UNMUTE, cur_ms, bps_pkg::FIELD_LEN_W'($urandom()),
                      bps_pkg::FIELD_CNT_W'($urandom()));
        else if (r < 90)
            push_beat(bps_pkg::ACT_TOGGLE, cur_ms, bps_pkg::FIELD_LEN_W'($urandom()),
                      bps_pkg::FIELD_CNT_W'($urandom()));
        else
            push_beat(bps_pkg::ACT_MUTE, cur_ms, bps_pkg::FIELD_LEN_W'($urandom()),
                      bps_pkg::FIELD_CNT_W'($urandom()));
        n_ticks = $urandom_range(2, 12);
        repeat (n_ticks)
        begin
            cur_ms = cur_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 19) == 0)
                push_beat(bps_pkg::ACT_TOGGLE, cur_ms, '0, '0);
            else
                push_beat(bps_pkg::ACT_TICK, cur_ms, bps_pkg::FIELD_LEN_W'($urandom()),
                          bps_pkg::FIELD_CNT_W'($urandom()));
        end
    endtask

    // Anything at all, spare action codes included.
    task automatic gen_noise();
        push_beat(bps_pkg::ACTION_W'($urandom_range(0, 7)), $urandom(),
                  bps_pkg::FIELD_LEN_W'($urandom()), bps_pkg::FIELD_CNT_W'($urandom()));
    endtask

    task automatic gen_random_phase();
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 75)
                gen_run();
            else
                gen_noise();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats at the reset register settings.
        push_beat(bps_pkg::ACT_TICK, 32'd0, '0, '0);         // reached, nothing left: drive off
        push_beat(bps_pkg::ACT_BEEP, 32'd10, 16'd5, 16'd0);  // zero count dropped
        push_beat(bps_pkg::ACT_BEEP, 32'd100, 16'd20, 16'd2);
        push_beat(bps_pkg::ACT_TICK, 32'd110, '0, '0);       // not yet reached
        push_beat(bps_pkg::ACT_TICK, 32'd120, '0, '0);       // into the gap
        push_beat(bps_pkg::ACT_TICK, 32'd220, '0, '0);       // second beep
        push_beat(bps_pkg::ACT_TICK, 32'd240, '0, '0);       // run spent
        push_beat(bps_pkg::ACT_MUTE, 32'd300, '0, '0);
        push_beat(bps_pkg::ACT_BEEP, 32'd310, 16'd10, 16'd3);  // dropped while muted
        push_beat(bps_pkg::ACT_MUTE, 32'd320, '0, '0);       // already muted
        push_beat(bps_pkg::ACT_TOGGLE, 32'd330, '0, '0);     // unmute, three blips
        push_beat(bps_pkg::ACT_TOGGLE, 32'd340, '0, '0);     // mute again
        push_beat(bps_pkg::ACT_UNMUTE, 32'd350, '0, '0);
        push_beat(bps_pkg::ACT_BEEP, 32'hFFFF_FFF0, 16'h0020, 16'd1);  // target wraps past zero
        push_beat(bps_pkg::ACT_TICK, 32'd5, '0, '0);
        push_beat(bps_pkg::ACT_TICK, 32'h0000_0010, '0, '0);
        push_beat(bps_pkg::ACT_BEEP, 32'd1000, 16'd100, 16'd1);
        push_beat(bps_pkg::ACT_TICK, 32'd1100 - 32'd60000, '0, '0);  // far behind: wrapped
        push_beat(bps_pkg::ACT_BEEP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        push_beat(bps_pkg::ACT_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        push_beat(ACT_SPARE, 32'd0, '0, '0);
        push_beat(ACT_SPARE_TOP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();

        // Random sequences at reset settings, no idling at first.
        send_idle = 1'b0;
        recv_idle = 1'b0;
        phase_items = 0;
        repeat (30) gen_run();
        wait_idle();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        gen_random_phase();
        wait_idle();

        // Low extremes: zero gaps and blips, every lag counts as wrapped, inverted levels.
        set_regs(16'd0, 16'd0, 32'd0, 1'b0, 1'b1);
        step_max = 20;
        dur_max  = 20;
        gen_random_phase();
        wait_idle();

        // High extremes: no wrap detection, long timings, both levels high.
        set_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        step_max = 20000;
        dur_max  = 30000;
        gen_random_phase();
        wait_idle();

        // Short timings with a tight wrap window; the output holds off while
        // the sender keeps offering beats back to back.
        set_regs(16'd20, 16'd10, 32'd1000, 1'b1, 1'b0);
        step_max = 15;
        dur_max  = 15;
        send_idle = 1'b0;
        hold_req++;
        gen_random_phase();
        wait_idle();
        send_idle = 1'b1;

        repeat (10) @(posedge clk);
        $display("%0d beats sent, %0d results checked across %0d register settings",
                 sent_cnt, checked_cnt, setting_cnt);
        $display("covered runs, mute blips, time wrap, spare codes and a long output hold-off");
        if (fail_cnt == 0)
            $display("beep_pattern_sequencer_core: match");
        else
            $display("beep_pattern_sequencer_core: mismatch");
        $finish;
    end

endmodule
